/* src/tms_pkg.sv */
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, codes and the microcode ROM of the tape-machine step unit.
// ----------------------------------------------------------------------------
package tms_pkg;

  // Microcode address.
  typedef logic [4:0] uaddr_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

  // Command codes.
  localparam logic [3:0] CMD_RIGHT     = 4'd0;
  localparam logic [3:0] CMD_LEFT      = 4'd1;
  localparam logic [3:0] CMD_ADD       = 4'd2;
  localparam logic [3:0] CMD_SUB       = 4'd3;
  localparam logic [3:0] CMD_OUTPUT    = 4'd4;
  localparam logic [3:0] CMD_INPUT     = 4'd5;
  localparam logic [3:0] CMD_LOOP      = 4'd6;
  localparam logic [3:0] CMD_CLEAR     = 4'd7;
  localparam logic [3:0] CMD_SEEK_R    = 4'd8;
  localparam logic [3:0] CMD_SEEK_L    = 4'd9;
  localparam logic [3:0] CMD_MOVE_ADD  = 4'd10;

  // Tape write data select.
  localparam logic [2:0] WD_ZERO = 3'd0;
  localparam logic [2:0] WD_ADD  = 3'd1;
  localparam logic [2:0] WD_SUB  = 3'd2;
  localparam logic [2:0] WD_IN   = 3'd3;
  localparam logic [2:0] WD_MAC  = 3'd4;

  // Working pointer operation.
  localparam logic [2:0] PT_NONE    = 3'd0;
  localparam logic [2:0] PT_ADD_AMT = 3'd1;
  localparam logic [2:0] PT_SUB_AMT = 3'd2;
  localparam logic [2:0] PT_ADD_STR = 3'd3;
  localparam logic [2:0] PT_SUB_STR = 3'd4;

  // Range fault checks.
  localparam logic [2:0] FC_NONE   = 3'd0;
  localparam logic [2:0] FC_MOVE_R = 3'd1;
  localparam logic [2:0] FC_MOVE_L = 3'd2;
  localparam logic [2:0] FC_SEEK_R = 3'd3;
  localparam logic [2:0] FC_SEEK_L = 3'd4;
  localparam logic [2:0] FC_DST    = 3'd5;

  // Sequencer jump conditions.
  localparam logic [1:0] JC_NONE   = 2'd0;
  localparam logic [1:0] JC_ALWAYS = 2'd1;
  localparam logic [1:0] JC_NZ     = 2'd2;

  // Tape address select.
  localparam logic AS_PTR = 1'b0;
  localparam logic AS_DST = 1'b1;

  // Microcode addresses.
  localparam uaddr_t UA_FIN       = 5'd0;
  localparam uaddr_t UA_RIGHT     = 5'd1;
  localparam uaddr_t UA_LEFT      = 5'd2;
  localparam uaddr_t UA_ADD_A     = 5'd3;
  localparam uaddr_t UA_ADD_B     = 5'd4;
  localparam uaddr_t UA_SUB_A     = 5'd5;
  localparam uaddr_t UA_SUB_B     = 5'd6;
  localparam uaddr_t UA_OUT_A     = 5'd7;
  localparam uaddr_t UA_OUT_B     = 5'd8;
  localparam uaddr_t UA_IN        = 5'd9;
  localparam uaddr_t UA_LOOP_A    = 5'd10;
  localparam uaddr_t UA_LOOP_B    = 5'd11;
  localparam uaddr_t UA_CLEAR     = 5'd12;
  localparam uaddr_t UA_SKR_A     = 5'd13;
  localparam uaddr_t UA_SKR_B     = 5'd14;
  localparam uaddr_t UA_SKR_FIN   = 5'd15;
  localparam uaddr_t UA_SKL_A     = 5'd16;
  localparam uaddr_t UA_SKL_B     = 5'd17;
  localparam uaddr_t UA_SKL_FIN   = 5'd18;
  localparam uaddr_t UA_MA_A      = 5'd19;
  localparam uaddr_t UA_MA_B      = 5'd20;
  localparam uaddr_t UA_MA_C      = 5'd21;
  localparam uaddr_t UA_MA_D      = 5'd22;
  localparam uaddr_t UA_UNKNOWN   = 5'd23;
  localparam uaddr_t UA_HALT      = 5'd24;

  // One control word of the sequencer.
  typedef struct packed {
    logic       rd;          // issue a tape read
    logic       wr;          // issue a tape write
    logic       addr_sel;    // tape address: pointer or move-add destination
    logic [2:0] wd_sel;      // tape write data
    logic [2:0] ptr_op;      // working pointer update
    logic [2:0] fail;        // range check that ends the command with a fault
    logic [1:0] jump;        // jump condition
    uaddr_t     target;      // jump target
    logic       fin;         // last step: deliver the result
    logic [1:0] status;      // result status when no fault fires
    logic       cell_rd;     // result cell value comes from the read data
    logic       is_out;      // result is an emitted byte
    logic       latch_prod;  // capture cell times delta
  } ctl_word_t;

  // Microcode ROM.
  function automatic ctl_word_t ucode(input uaddr_t ua);
    ctl_word_t cw;
    cw = '0;
    unique case (ua)
      UA_FIN, UA_SKR_FIN, UA_SKL_FIN: begin
        cw.fin = 1'b1;
      end
      UA_RIGHT: begin
        cw.fail = FC_MOVE_R; cw.ptr_op = PT_ADD_AMT;
        cw.jump = JC_ALWAYS; cw.target = UA_FIN;
      end
      UA_LEFT: begin
        cw.fail = FC_MOVE_L; cw.ptr_op = PT_SUB_AMT;
        cw.jump = JC_ALWAYS; cw.target = UA_FIN;
      end
      UA_ADD_A, UA_SUB_A, UA_OUT_A, UA_LOOP_A, UA_SKR_A, UA_SKL_A: begin
        cw.rd = 1'b1;
      end
      UA_ADD_B: begin
        cw.wr = 1'b1; cw.wd_sel = WD_ADD; cw.fin = 1'b1;
      end
      UA_SUB_B: begin
        cw.wr = 1'b1; cw.wd_sel = WD_SUB; cw.fin = 1'b1;
      end
      UA_OUT_B: begin
        cw.fin = 1'b1; cw.cell_rd = 1'b1; cw.is_out = 1'b1;
      end
      UA_IN: begin
        cw.wr = 1'b1; cw.wd_sel = WD_IN; cw.fin = 1'b1;
      end
      UA_LOOP_B: begin
        cw.fin = 1'b1; cw.cell_rd = 1'b1;
      end
      UA_CLEAR: begin
        cw.wr = 1'b1; cw.wd_sel = WD_ZERO; cw.fin = 1'b1;
      end
      UA_SKR_B: begin
        cw.jump = JC_NZ; cw.target = UA_SKR_A;
        cw.fail = FC_SEEK_R; cw.ptr_op = PT_ADD_STR;
      end
      UA_SKL_B: begin
        cw.jump = JC_NZ; cw.target = UA_SKL_A;
        cw.fail = FC_SEEK_L; cw.ptr_op = PT_SUB_STR;
      end
      UA_MA_A: begin
        cw.fail = FC_DST; cw.rd = 1'b1;
      end
      UA_MA_B: begin
        cw.rd = 1'b1; cw.addr_sel = AS_DST; cw.latch_prod = 1'b1;
      end
      UA_MA_C: begin
        cw.wr = 1'b1; cw.addr_sel = AS_DST; cw.wd_sel = WD_MAC;
      end
      UA_MA_D: begin
        cw.wr = 1'b1; cw.wd_sel = WD_ZERO; cw.fin = 1'b1;
      end
      UA_HALT: begin
        cw.fin = 1'b1; cw.status = ST_HALTED;
      end
      default: begin
        cw.fin = 1'b1; cw.status = ST_UNKNOWN;
      end
    endcase
    return cw;
  endfunction

  // Entry point of each command.
  function automatic uaddr_t entry(input logic [3:0] cmd);
    uaddr_t ua;
    unique case (cmd)
      CMD_RIGHT:    ua = UA_RIGHT;
      CMD_LEFT:     ua = UA_LEFT;
      CMD_ADD:      ua = UA_ADD_A;
      CMD_SUB:      ua = UA_SUB_A;
      CMD_OUTPUT:   ua = UA_OUT_A;
      CMD_INPUT:    ua = UA_IN;
      CMD_LOOP:     ua = UA_LOOP_A;
      CMD_CLEAR:    ua = UA_CLEAR;
      CMD_SEEK_R:   ua = UA_SKR_A;
      CMD_SEEK_L:   ua = UA_SKL_A;
      CMD_MOVE_ADD: ua = UA_MA_A;
      default:      ua = UA_UNKNOWN;
    endcase
    return ua;
  endfunction

endpackage

/* src/tape_machine_step_unit.sv */
// ----------------------------------------------------------------------------
// tape_machine_step_unit
// Executes one command of a byte-tape machine per input word.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one command word; the output
// channel (out_valid, out_stall) returns exactly one result word per command,
// in order. A word moves at a clock edge where valid is high and stall low.
//
// Each command runs as a short microcode routine on a single-port tape memory
// with registered read data. The word is taken, then the steps run in turn:
// input and clear write the cell; moves check the range, then finish; add,
// sub, output and loop test read the cell, then write or return it; move-add
// adds the source cell times delta to the destination and clears the source;
// a seek tests cells and steps on while they are nonzero; a halted or unknown
// command just finishes. The result appears in the output register at the end
// of the last step, and the next word is taken from the following cycle on.
//
// After reset the unit clears the tape one cell per cycle and holds in_stall
// high meanwhile. The pointer starts at TAPE_DEPTH/2.
// When the receiver stalls, the result stays in the output register; a
// command may still run, and its last step waits until the register is free.
// ----------------------------------------------------------------------------
module tape_machine_step_unit #(
  parameter int TAPE_DEPTH = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic [15:0]        amount,
  input  logic signed [15:0] move_offset,
  input  logic signed [15:0] move_delta,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               is_output,
  output logic [7:0]         cell_value
);

  // Pointer width and a width wide enough for pointer sums and offsets.
  localparam int PW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int SW = ((PW > 16) ? PW : 16) + 2;
  localparam logic [PW-1:0] PTR_INIT = PW'(TAPE_DEPTH / 2);
  localparam logic [PW-1:0] CLR_LAST = PW'(TAPE_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_X  = SW'(TAPE_DEPTH);

  // Tape memory, written and read through one port.
  logic [7:0] tape [TAPE_DEPTH];

  // Control state.
  logic              busy;
  logic              clearing;
  logic [PW-1:0]     clr_addr;
  logic [PW-1:0]     dp;
  logic [PW-1:0]     wp;
  logic              halted;
  tms_pkg::uaddr_t   upc;

  // Operands held for the running command.
  logic [15:0]        amt;
  logic signed [15:0] off;
  logic [7:0]         delta_lo;
  logic [7:0]         byte_in;
  logic [7:0]         rdata;
  logic [7:0]         prod;

  tms_pkg::ctl_word_t cw;
  assign cw = tms_pkg::ucode(upc);

  // Input handshake: a new word is taken only between commands.
  logic accept;
  assign in_stall = busy | clearing;
  assign accept   = in_valid & ~in_stall;

  // Pointer arithmetic shared by moves, seeks and the move-add destination.
  logic [15:0]        stride;
  logic [SW-1:0]      wp_x;
  logic [SW-1:0]      amt_x;
  logic [SW-1:0]      str_x;
  logic [SW-1:0]      sum_amt;
  logic [SW-1:0]      sum_str;
  logic signed [SW-1:0] dst;
  logic               dst_bad;

  assign stride  = (amt == 16'd0) ? 16'd1 : amt;
  assign wp_x    = SW'(wp);
  assign amt_x   = SW'(amt);
  assign str_x   = SW'(stride);
  assign sum_amt = wp_x + amt_x;
  assign sum_str = wp_x + str_x;
  assign dst     = $signed(wp_x) + SW'(off);
  assign dst_bad = dst[SW-1] | ($unsigned(dst) >= DEPTH_X);

  logic fault;
  always_comb begin
    case (cw.fail)
      tms_pkg::FC_MOVE_R: fault = (sum_amt >= DEPTH_X);
      tms_pkg::FC_MOVE_L: fault = (amt_x > wp_x);
      tms_pkg::FC_SEEK_R: fault = (sum_str >= DEPTH_X);
      tms_pkg::FC_SEEK_L: fault = (wp_x < str_x);
      tms_pkg::FC_DST:    fault = dst_bad;
      default:            fault = 1'b0;
    endcase
  end

  // A conditional word only acts when its jump is taken; a fault then wins
  // over the jump and ends the command.
  logic jump_taken;
  logic active;
  logic fail_hit;
  logic ends;
  logic out_free;
  logic step_go;
  logic finishing;

  assign jump_taken = (cw.jump == tms_pkg::JC_ALWAYS) ||
                      ((cw.jump == tms_pkg::JC_NZ) && (rdata != 8'd0));
  assign active     = (cw.jump != tms_pkg::JC_NZ) || (rdata != 8'd0);
  assign fail_hit   = active & fault;
  assign ends       = cw.fin | fail_hit;
  assign out_free   = ~out_valid | ~out_stall;
  assign step_go    = busy & (~ends | out_free);
  assign finishing  = step_go & ends;

  logic [PW-1:0] wp_next;
  always_comb begin
    case (cw.ptr_op)
      tms_pkg::PT_ADD_AMT: wp_next = sum_amt[PW-1:0];
      tms_pkg::PT_SUB_AMT: wp_next = PW'(wp_x - amt_x);
      tms_pkg::PT_ADD_STR: wp_next = sum_str[PW-1:0];
      tms_pkg::PT_SUB_STR: wp_next = PW'(wp_x - str_x);
      default:             wp_next = wp;
    endcase
  end

  // Result of the finishing step.
  logic [1:0] status_next;
  logic [7:0] cell_next;
  logic       is_out_next;
  assign status_next = fail_hit ? tms_pkg::ST_RANGE : cw.status;
  assign cell_next   = (~fail_hit & cw.cell_rd) ? rdata : 8'd0;
  assign is_out_next = ~fail_hit & cw.is_out;

  // Tape port.
  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [15:0]   prod_full;

  assign prod_full = 16'(rdata) * 16'(delta_lo);

  always_comb begin
    if (clearing) begin
      mem_addr = clr_addr;
    end else if (cw.addr_sel == tms_pkg::AS_DST) begin
      mem_addr = dst[PW-1:0];
    end else begin
      mem_addr = wp;
    end
  end

  always_comb begin
    case (cw.wd_sel)
      tms_pkg::WD_ADD: mem_wdata = rdata + amt[7:0];
      tms_pkg::WD_SUB: mem_wdata = rdata - amt[7:0];
      tms_pkg::WD_IN:  mem_wdata = byte_in;
      tms_pkg::WD_MAC: mem_wdata = rdata + prod;
      default:         mem_wdata = 8'd0;
    endcase
    if (clearing) begin
      mem_wdata = 8'd0;
    end
  end

  assign mem_we = clearing | (step_go & cw.wr & ~fail_hit);
  assign mem_re = ~clearing & step_go & cw.rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= tape[mem_addr];
    end
  end

  // Operand registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      amt      <= amount;
      off      <= move_offset;
      delta_lo <= move_delta[7:0];
      byte_in  <= in_byte;
    end
    if (step_go && cw.latch_prod) begin
      prod <= prod_full[7:0];
    end
    if (finishing) begin
      status     <= status_next;
      cell_value <= cell_next;
      is_output  <= is_out_next;
    end
  end

  // Sequencer, pointer, halt flag and clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      dp        <= PTR_INIT;
      wp        <= PTR_INIT;
      halted    <= 1'b0;
      out_valid <= 1'b0;
      upc       <= tms_pkg::UA_FIN;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (out_valid && !out_stall && !finishing) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        wp   <= dp;
        upc  <= halted ? tms_pkg::UA_HALT : tms_pkg::entry(command);
      end else if (step_go) begin
        if (finishing) begin
          busy      <= 1'b0;
          out_valid <= 1'b1;
          if (status_next == tms_pkg::ST_OK) begin
            dp <= wp;
          end
          if (status_next == tms_pkg::ST_RANGE || status_next == tms_pkg::ST_UNKNOWN) begin
            halted <= 1'b1;
          end
        end else begin
          if (active) begin
            wp <= wp_next;
          end
          upc <= jump_taken ? cw.target : upc + 5'd1;
        end
      end
    end
  end

  // A fault always leaves the machine halted.
  assert property (@(posedge clk) disable iff (rst)
    (finishing && fail_hit) |=> halted)
    else $error("range fault did not set the halt flag");

  // Once halted, the machine stays halted until reset.
  assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  // The committed pointer always lies on the tape.
  assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, dp} < (PW+1)'(TAPE_DEPTH)))
    else $error("data pointer left the tape");

  // No command runs while the tape is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !busy)
    else $error("command ran during the clearing pass");

endmodule
